// ----- rtl/core/kruskal_minimum_spanning_tree_unit_macros.svh -----
`ifndef KRUSKAL_MINIMUM_SPANNING_TREE_UNIT_MACROS_SVH
`define KRUSKAL_MINIMUM_SPANNING_TREE_UNIT_MACROS_SVH

// same-cycle implication
`define KMST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kmst assertion failed");

// next-cycle implication
`define KMST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kmst assertion failed");

`endif

// ----- rtl/core/kmst_pkg.sv -----
`timescale 1ns / 1ps
package kmst_pkg;
    localparam int NODE_W    = 6;
    localparam int W_BITS    = 16;
    localparam int MAX_NODES = 32;
    localparam int MAX_EDGES = 256;
    localparam int EIDX_W    = $clog2(MAX_EDGES);
    localparam int CNT_W     = EIDX_W + 1;
    localparam int COST_W    = 21;
    localparam int RANK_W    = 3;
    localparam int RANK_TOP  = 7;

    typedef struct packed {
        logic [NODE_W-1:0]        src;
        logic [NODE_W-1:0]        dst;
        logic signed [W_BITS-1:0] w;
    } t_edge;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_STORE,
        OP_RD_T,
        OP_LATCH_T,
        OP_RD_PREV,
        OP_SHIFT,
        OP_PLACE,
        OP_I_CLR,
        OP_RD_E,
        OP_LOAD_E,
        OP_STEP,
        OP_SAVE_A,
        OP_SAVE_B,
        OP_NEXT,
        OP_UNION1,
        OP_UNION2,
        OP_EMIT_EDGE,
        OP_EMIT_TOT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic i_done;
        logic j_zero;
        logic prev_gt;
        logic uf_root;
        logic same_root;
        logic eq_rank;
        logic out_free;
    } t_dp_stat;
endpackage

// ----- rtl/core/kmst_ctrl.sv -----
`timescale 1ns / 1ps
module kmst_ctrl import kmst_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_last_edge,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);
    typedef enum logic [3:0] {
        ST_LOAD, ST_SORT_I, ST_SORT_TL, ST_SORT_CHK, ST_SORT_CMP,
        ST_K_I, ST_K_EL, ST_FA_REQ, ST_FA_CHK, ST_FB_REQ, ST_FB_CHK,
        ST_K_DEC, ST_K_UN2, ST_K_OUT, ST_TOT
    } t_state;

    t_state r_state, n_state;
    t_dp_op op;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    op = OP_STORE;
                    if (i_last_edge) n_state = ST_SORT_I;
                end
            end
            ST_SORT_I: begin
                if (i_stat.i_done) begin
                    op = OP_I_CLR;
                    n_state = ST_K_I;
                end else begin
                    op = OP_RD_T;
                    n_state = ST_SORT_TL;
                end
            end
            ST_SORT_TL: begin
                op = OP_LATCH_T;
                n_state = ST_SORT_CHK;
            end
            ST_SORT_CHK: begin
                if (i_stat.j_zero) begin
                    op = OP_PLACE;
                    n_state = ST_SORT_I;
                end else begin
                    op = OP_RD_PREV;
                    n_state = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP: begin
                if (i_stat.prev_gt) begin
                    op = OP_SHIFT;
                    n_state = ST_SORT_CHK;
                end else begin
                    op = OP_PLACE;
                    n_state = ST_SORT_I;
                end
            end
            ST_K_I: begin
                if (i_stat.i_done) begin
                    n_state = ST_TOT;
                end else begin
                    op = OP_RD_E;
                    n_state = ST_K_EL;
                end
            end
            ST_K_EL: begin
                op = OP_LOAD_E;
                n_state = ST_FA_REQ;
            end
            ST_FA_REQ: n_state = ST_FA_CHK;
            ST_FA_CHK: begin
                if (i_stat.uf_root) begin
                    op = OP_SAVE_A;
                    n_state = ST_FB_REQ;
                end else begin
                    op = OP_STEP;
                    n_state = ST_FA_REQ;
                end
            end
            ST_FB_REQ: n_state = ST_FB_CHK;
            ST_FB_CHK: begin
                if (i_stat.uf_root) begin
                    op = OP_SAVE_B;
                    n_state = ST_K_DEC;
                end else begin
                    op = OP_STEP;
                    n_state = ST_FB_REQ;
                end
            end
            ST_K_DEC: begin
                if (i_stat.same_root) begin
                    op = OP_NEXT;
                    n_state = ST_K_I;
                end else begin
                    op = OP_UNION1;
                    n_state = i_stat.eq_rank ? ST_K_UN2 : ST_K_OUT;
                end
            end
            ST_K_UN2: begin
                op = OP_UNION2;
                n_state = ST_K_OUT;
            end
            ST_K_OUT: begin
                if (i_stat.out_free) begin
                    op = OP_EMIT_EDGE;
                    n_state = ST_K_I;
                end
            end
            ST_TOT: begin
                if (i_stat.out_free) begin
                    op = OP_EMIT_TOT;
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_LOAD;
        else          r_state <= n_state;
    end

    assign o_cmd.op   = op;
    assign o_in_stall = (r_state != ST_LOAD);
endmodule

// ----- rtl/core/kmst_dp.sv -----
`timescale 1ns / 1ps
`include "kruskal_minimum_spanning_tree_unit_macros.svh"
module kmst_dp import kmst_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [NODE_W-1:0]        i_src_node,
    input  logic [NODE_W-1:0]        i_dst_node,
    input  logic signed [W_BITS-1:0] i_edge_weight,
    input  logic                     i_cfg_valid,
    input  logic [NODE_W-1:0]        i_cfg_data,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic                     o_item_kind,
    output logic [NODE_W-1:0]        o_tree_src,
    output logic [NODE_W-1:0]        o_tree_dst,
    output logic signed [W_BITS-1:0] o_tree_weight,
    output logic signed [COST_W-1:0] o_total_cost,
    output logic                     o_dropped_flag,
    output logic                     o_last_result
);
    localparam int UF_W = NODE_W + RANK_W;
    localparam logic signed [COST_W:0] COST_HI = (COST_W+1)'((1 << (COST_W - 1)) - 1);
    localparam logic signed [COST_W:0] COST_LO = -(COST_W+1)'(1 << (COST_W - 1));

    t_edge             e_mem [0:MAX_EDGES-1];
    logic [UF_W-1:0]   uf_mem [0:MAX_NODES];
    logic [MAX_NODES:0] r_uvalid;

    logic [NODE_W-1:0]        r_num_nodes;
    logic [CNT_W-1:0]         r_cnt, r_i, r_j;
    logic                     r_drop;
    logic signed [COST_W-1:0] r_cost;
    t_edge                    r_t, r_e_rd;
    logic [NODE_W-1:0]        r_fv, r_ra, r_rb;
    logic [RANK_W-1:0]        r_rka, r_rkb;
    logic [UF_W-1:0]          r_uf_rd;
    logic                     r_uf_vld;

    logic                     r_ovld, r_okind, r_odrop, r_olast;
    logic [NODE_W-1:0]        r_osrc, r_odst;
    logic signed [W_BITS-1:0] r_ow;
    logic signed [COST_W-1:0] r_ocost;

    logic [NODE_W-1:0] n_lim, uf_par;
    logic [RANK_W-1:0] uf_rank;
    logic              in_ok, out_free, e_we, u_we;
    logic [EIDX_W-1:0] e_ra, e_wa;
    t_edge             e_wd, in_edge;
    logic [NODE_W-1:0] u_wa;
    logic [UF_W-1:0]   u_wd;
    logic signed [COST_W:0] sum;

    assign n_lim = (r_num_nodes > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : r_num_nodes;
    assign in_ok = (i_src_node != '0) && (i_src_node <= n_lim) &&
                   (i_dst_node != '0) && (i_dst_node <= n_lim) &&
                   (r_cnt < CNT_W'(MAX_EDGES));
    assign in_edge  = '{src: i_src_node, dst: i_dst_node, w: i_edge_weight};
    assign out_free = !r_ovld || !i_out_stall;
    assign uf_par   = r_uf_vld ? r_uf_rd[UF_W-1:RANK_W] : r_fv;
    assign uf_rank  = r_uf_vld ? r_uf_rd[RANK_W-1:0] : '0;
    assign sum      = (COST_W+1)'(r_cost) + (COST_W+1)'(r_t.w);

    always_comb begin
        e_ra = r_i[EIDX_W-1:0];
        e_we = 1'b0;
        e_wa = r_j[EIDX_W-1:0];
        e_wd = r_t;
        u_we = 1'b0;
        u_wa = r_ra;
        u_wd = {r_rb, r_rka};
        case (i_cmd.op)
            OP_STORE: begin
                e_we = in_ok;
                e_wa = r_cnt[EIDX_W-1:0];
                e_wd = in_edge;
            end
            OP_RD_PREV: e_ra = EIDX_W'(r_j - 1'b1);
            OP_SHIFT: begin
                e_we = 1'b1;
                e_wd = r_e_rd;
            end
            OP_PLACE: e_we = 1'b1;
            OP_UNION1: begin
                u_we = 1'b1;
                if (r_rkb < r_rka) begin
                    u_wa = r_rb;
                    u_wd = {r_ra, r_rkb};
                end
            end
            OP_UNION2: begin
                u_we = 1'b1;
                u_wa = r_rb;
                u_wd = {r_rb, (r_rkb < RANK_W'(RANK_TOP)) ? r_rkb + 1'b1 : r_rkb};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (e_we) e_mem[e_wa] <= e_wd;
        r_e_rd <= e_mem[e_ra];
        if (u_we) uf_mem[u_wa] <= u_wd;
        r_uf_rd  <= uf_mem[r_fv];
        r_uf_vld <= r_uvalid[r_fv];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= NODE_W'(MAX_NODES);
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_cost      <= '0;
            r_uvalid    <= '0;
            r_ovld      <= 1'b0;
        end else begin
            if (i_cfg_valid) r_num_nodes <= i_cfg_data;
            if (r_ovld && !i_out_stall &&
                i_cmd.op != OP_EMIT_EDGE && i_cmd.op != OP_EMIT_TOT) r_ovld <= 1'b0;
            if (u_we) r_uvalid[u_wa] <= 1'b1;
            case (i_cmd.op)
                OP_STORE: begin
                    r_i <= '0;
                    if (in_ok) r_cnt  <= r_cnt + 1'b1;
                    else       r_drop <= 1'b1;
                end
                OP_RD_T:    r_j <= r_i;
                OP_LATCH_T: r_t <= r_e_rd;
                OP_SHIFT:   r_j <= r_j - 1'b1;
                OP_PLACE:   r_i <= r_i + 1'b1;
                OP_I_CLR:   r_i <= '0;
                OP_LOAD_E: begin
                    r_t  <= r_e_rd;
                    r_fv <= r_e_rd.src;
                end
                OP_STEP: r_fv <= uf_par;
                OP_SAVE_A: begin
                    r_ra  <= r_fv;
                    r_rka <= uf_rank;
                    r_fv  <= r_t.dst;
                end
                OP_SAVE_B: begin
                    r_rb  <= r_fv;
                    r_rkb <= uf_rank;
                end
                OP_NEXT: r_i <= r_i + 1'b1;
                OP_UNION1: begin
                    if (sum > COST_HI)      r_cost <= COST_HI[COST_W-1:0];
                    else if (sum < COST_LO) r_cost <= COST_LO[COST_W-1:0];
                    else                    r_cost <= sum[COST_W-1:0];
                end
                OP_EMIT_EDGE: begin
                    r_i     <= r_i + 1'b1;
                    r_ovld  <= 1'b1;
                    r_okind <= 1'b0;
                    r_osrc  <= r_t.src;
                    r_odst  <= r_t.dst;
                    r_ow    <= r_t.w;
                    r_ocost <= r_cost;
                    r_odrop <= r_drop;
                    r_olast <= 1'b0;
                end
                OP_EMIT_TOT: begin
                    r_ovld   <= 1'b1;
                    r_okind  <= 1'b1;
                    r_osrc   <= '0;
                    r_odst   <= '0;
                    r_ow     <= '0;
                    r_ocost  <= r_cost;
                    r_odrop  <= r_drop;
                    r_olast  <= 1'b1;
                    r_cnt    <= '0;
                    r_drop   <= 1'b0;
                    r_cost   <= '0;
                    r_uvalid <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.i_done    = (r_i >= r_cnt);
    assign o_stat.j_zero    = (r_j == '0);
    assign o_stat.prev_gt   = (r_e_rd.w > r_t.w);
    assign o_stat.uf_root   = (uf_par == r_fv);
    assign o_stat.same_root = (r_ra == r_rb);
    assign o_stat.eq_rank   = (r_rka == r_rkb);
    assign o_stat.out_free  = out_free;

    assign o_out_valid    = r_ovld;
    assign o_item_kind    = r_okind;
    assign o_tree_src     = r_osrc;
    assign o_tree_dst     = r_odst;
    assign o_tree_weight  = r_ow;
    assign o_total_cost   = r_ocost;
    assign o_dropped_flag = r_odrop;
    assign o_last_result  = r_olast;

    `KMST_ASSERT_NOW(a_cnt_cap, 1'b1, r_cnt <= CNT_W'(MAX_EDGES))
    `KMST_ASSERT_NOW(a_emit_free, (i_cmd.op == OP_EMIT_EDGE || i_cmd.op == OP_EMIT_TOT), out_free)
    `KMST_ASSERT_NXT(a_tot_clear, i_cmd.op == OP_EMIT_TOT, r_cnt == '0 && !r_drop && r_uvalid == '0)
endmodule

// ----- rtl/core/kruskal_minimum_spanning_tree_unit.sv -----
`timescale 1ns / 1ps
// Minimum spanning tree unit (Kruskal, union-find by rank).
// Input channel: i_in_valid / o_in_stall with src, dst, weight, last_edge.
//   Edges load one per cycle; o_in_stall is high while a graph is computed.
// Output channel: o_out_valid / i_out_stall. Tree edges come in ascending
//   weight order, then one total item with last_result set.
// Config: i_cfg_valid / o_cfg_ready (always ready) writes num_nodes.
// After the last edge: stable insertion sort over the edge memory; then,
//   for each sorted edge, a union-find walk from each endpoint to its root,
//   a second union write when the ranks tie and an emitted item for each
//   edge that joins two trees, then the total item.
// Throughput: one graph at a time; a new graph loads after the total item
//   is handed to the output register.
// A stalled receiver holds the output register and pauses the run.
// Reset (synchronous, active low) clears the edge count, cost, drop flag,
//   union-find table and sets num_nodes to 32; no clearing pass is needed.
module kruskal_minimum_spanning_tree_unit import kmst_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [NODE_W-1:0]        i_src_node,
    input  logic [NODE_W-1:0]        i_dst_node,
    input  logic signed [W_BITS-1:0] i_edge_weight,
    input  logic                     i_last_edge,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [NODE_W-1:0]        i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_item_kind,
    output logic [NODE_W-1:0]        o_tree_src,
    output logic [NODE_W-1:0]        o_tree_dst,
    output logic signed [W_BITS-1:0] o_tree_weight,
    output logic signed [COST_W-1:0] o_total_cost,
    output logic                     o_dropped_flag,
    output logic                     o_last_result
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    kmst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_edge (i_last_edge),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall)
    );

    kmst_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_src_node     (i_src_node),
        .i_dst_node     (i_dst_node),
        .i_edge_weight  (i_edge_weight),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_item_kind    (o_item_kind),
        .o_tree_src     (o_tree_src),
        .o_tree_dst     (o_tree_dst),
        .o_tree_weight  (o_tree_weight),
        .o_total_cost   (o_total_cost),
        .o_dropped_flag (o_dropped_flag),
        .o_last_result  (o_last_result)
    );
endmodule

// ----- tb/sv/tb_kruskal_minimum_spanning_tree_unit.sv -----
`timescale 1ns / 1ps
module tb_kruskal_minimum_spanning_tree_unit;
    import kmst_pkg::*;

    typedef struct {
        logic [NODE_W-1:0]        src;
        logic [NODE_W-1:0]        dst;
        logic signed [W_BITS-1:0] w;
        logic                     last;
    } t_edge_req;

    typedef struct {
        logic                     kind;
        logic [NODE_W-1:0]        src;
        logic [NODE_W-1:0]        dst;
        logic signed [W_BITS-1:0] w;
        logic signed [COST_W-1:0] cost;
        logic                     dropped;
        logic                     last;
    } t_tree_item;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [NODE_W-1:0]        i_src_node;
    logic [NODE_W-1:0]        i_dst_node;
    logic signed [W_BITS-1:0] i_edge_weight;
    logic                     i_last_edge;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [NODE_W-1:0]        i_cfg_data;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic                     o_item_kind;
    logic [NODE_W-1:0]        o_tree_src;
    logic [NODE_W-1:0]        o_tree_dst;
    logic signed [W_BITS-1:0] o_tree_weight;
    logic signed [COST_W-1:0] o_total_cost;
    logic                     o_dropped_flag;
    logic                     o_last_result;

    kruskal_minimum_spanning_tree_unit dut (.*);

    t_edge_req  pending_edges[$];
    t_tree_item expected_tree[$];
    int         errors;
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         hold_send;

    // predictor state
    logic [NODE_W-1:0]        node_limit;
    logic [NODE_W-1:0]        es_src[MAX_EDGES];
    logic [NODE_W-1:0]        es_dst[MAX_EDGES];
    logic signed [W_BITS-1:0] es_w[MAX_EDGES];
    int                       stored_cnt;
    int                       uf_parent[MAX_NODES+1];
    int                       uf_rank[MAX_NODES+1];
    bit                       drop_seen;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic int find_root(int v);
        int r;
        int nx;
        r = v;
        while (uf_parent[r] != r) r = uf_parent[r];
        while (uf_parent[v] != r) begin
            nx = uf_parent[v];
            uf_parent[v] = r;
            v = nx;
        end
        return r;
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i <= MAX_NODES; i++) begin
            uf_parent[i] = i;
            uf_rank[i] = 0;
        end
        stored_cnt = 0;
        drop_seen = 0;
    endfunction

    task automatic predict_mst(t_edge_req e);
        int n;
        int a;
        int b;
        int j;
        int cost;
        logic [NODE_W-1:0] ts;
        logic [NODE_W-1:0] td;
        logic signed [W_BITS-1:0] tw;
        t_tree_item t;
        n = (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
        if (e.src < 1 || e.src > n || e.dst < 1 || e.dst > n || stored_cnt >= MAX_EDGES) begin
            drop_seen = 1;
        end else begin
            es_src[stored_cnt] = e.src;
            es_dst[stored_cnt] = e.dst;
            es_w[stored_cnt] = e.w;
            stored_cnt++;
        end
        if (!e.last) return;
        for (int i = 1; i < stored_cnt; i++) begin
            ts = es_src[i]; td = es_dst[i]; tw = es_w[i];
            j = i;
            while (j > 0 && es_w[j-1] > tw) begin
                es_src[j] = es_src[j-1]; es_dst[j] = es_dst[j-1]; es_w[j] = es_w[j-1];
                j--;
            end
            es_src[j] = ts; es_dst[j] = td; es_w[j] = tw;
        end
        cost = 0;
        for (int i = 0; i < stored_cnt; i++) begin
            a = find_root(es_src[i]);
            b = find_root(es_dst[i]);
            if (a != b) begin
                cost += es_w[i];
                if (cost > 1048575) cost = 1048575;
                if (cost < -1048576) cost = -1048576;
                if (uf_rank[a] < uf_rank[b]) uf_parent[a] = b;
                else if (uf_rank[b] < uf_rank[a]) uf_parent[b] = a;
                else begin
                    uf_parent[a] = b;
                    if (uf_rank[b] < RANK_TOP) uf_rank[b]++;
                end
                t = '{1'b0, es_src[i], es_dst[i], es_w[i], cost[COST_W-1:0], drop_seen, 1'b0};
                expected_tree = {expected_tree, t};
            end
        end
        t = '{1'b1, '0, '0, '0, cost[COST_W-1:0], drop_seen, 1'b1};
        expected_tree = {expected_tree, t};
        clear_graph();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) predict_mst('{i_src_node, i_dst_node, i_edge_weight, i_last_edge});
            if (pending_edges.size() > 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
                t_edge_req e;
                e = pending_edges.pop_front();
                i_in_valid <= 1'b1;
                i_src_node <= e.src;
                i_dst_node <= e.dst;
                i_edge_weight <= e.w;
                i_last_edge <= e.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_tree.size() == 0) begin
                    $display("%0t: unexpected request kind=%0d", $time, o_item_kind);
                    errors++;
                end else begin
                    t_tree_item x;
                    x = expected_tree.pop_front();
                    if (x.kind !== o_item_kind || x.src !== o_tree_src || x.dst !== o_tree_dst ||
                        x.w !== o_tree_weight || x.cost !== o_total_cost ||
                        x.dropped !== o_dropped_flag || x.last !== o_last_result) begin
                        $display("%0t: expected %0d %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d %0d",
                            $time, x.kind, x.src, x.dst, x.w, x.cost, x.dropped, x.last,
                            o_item_kind, o_tree_src, o_tree_dst, o_tree_weight, o_total_cost,
                            o_dropped_flag, o_last_result);
                        errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic void add_edge(int s, int d, int w, bit last);
        t_edge_req e;
        e = '{s[NODE_W-1:0], d[NODE_W-1:0], w[W_BITS-1:0], last};
        pending_edges = {pending_edges, e};
    endfunction

    function automatic void add_random_graph(int n, int cnt);
        int s;
        int d;
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(19) == 0) begin
                s = $urandom_range(63); d = $urandom_range(63);
            end else begin
                s = $urandom_range(n, 1); d = $urandom_range(n, 1);
            end
            add_edge(s, d, ($urandom_range(3) == 0) ? $urandom_range(65535) :
                     $urandom_range(20) - 10, i == cnt - 1);
        end
    endfunction

    task automatic drain();
        while (pending_edges.size() > 0 || i_in_valid || expected_tree.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_nodes(int n);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n[NODE_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        node_limit = n[NODE_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        errors = 0;
        hold_send = 0;
        send_idle_pct = 24;
        recv_stall_pct = 76;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_src_node = '0;
        i_dst_node = '0;
        i_edge_weight = '0;
        i_last_edge = 1'b0;
        node_limit = 6'd32;
        clear_graph();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, self loop, bad endpoints, ties, long chains
        add_edge(1, 32, 32767, 0);
        add_edge(32, 1, -32768, 0);
        add_edge(5, 5, -100, 0);
        add_edge(0, 3, 7, 0);
        add_edge(3, 33, 7, 0);
        add_edge(63, 63, 1, 0);
        add_edge(2, 3, 4, 0);
        add_edge(3, 4, 4, 0);
        add_edge(2, 4, 4, 1);
        add_edge(0, 0, 0, 1);
        for (int i = 1; i < 32; i++) add_edge(i, i + 1, 32767, 0);
        add_edge(1, 32, -1, 1);
        for (int i = 1; i < 32; i++) add_edge(i, i + 1, -32768, i == 31);
        drain();

        write_nodes(1);
        add_edge(1, 1, 5, 0);
        add_edge(1, 2, 5, 1);
        drain();
        write_nodes(0);
        add_edge(1, 1, 3, 1);
        drain();
        write_nodes(63);
        add_random_graph(32, 8);
        drain();

        // sender waits until every expected request has come
        write_nodes(8);
        add_random_graph(8, 10);
        while (pending_edges.size() > 0 || i_in_valid) @(posedge i_clk);
        hold_send = 1;
        add_random_graph(8, 6);
        while (expected_tree.size() > 0) @(posedge i_clk);
        hold_send = 0;

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 76; recv_stall_pct = 24; end
            if (ph == 2) begin send_idle_pct = 0; recv_stall_pct = 0; end
            drain();
            write_nodes((ph == 0) ? 32 : $urandom_range(31, 2));
            for (int g = 0; g < 6; g++) add_random_graph(node_limit, $urandom_range(16, 1));
        end
        drain();
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/kmst_pkg.sv
rtl/core/kmst_ctrl.sv
rtl/core/kmst_dp.sv
rtl/core/kruskal_minimum_spanning_tree_unit.sv
tb/sv/tb_kruskal_minimum_spanning_tree_unit.sv
